[rtl/tvp_pkg.sv]
// ----------------------------------------------------------------------------
// tvp_pkg
// Shared constants and types of the trapezoidal velocity profile unit.
// ----------------------------------------------------------------------------
package tvp_pkg;

  localparam int POSITION_BITS_DEF    = 16;
  localparam int SPEED_BITS           = 8;
  localparam int ACCEL_BITS           = 8;
  localparam int CFG_INDEX_BITS       = 2;
  localparam int SQRT_IN_BITS         = 2 * SPEED_BITS;
  localparam int SQRT_STEPS           = SPEED_BITS;
  localparam int SQRT_STEPS_PER_STAGE = 4;

  // configuration register map
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MOVE_START  = 2'd0,
    REG_MOVE_END    = 2'd1,
    REG_SPEED_LIMIT = 2'd2,
    REG_ACCEL_LIMIT = 2'd3
  } cfg_reg_t;

  // partial state of the digit-by-digit square root
  typedef struct packed {
    logic [SQRT_IN_BITS-1:0] rem;
    logic [SQRT_IN_BITS-1:0] root;
  } tvp_sqrt_t;

endpackage

[rtl/tvp_if.sv]
// ----------------------------------------------------------------------------
// tvp_if
// Valid/ready channels: encoder samples in, velocity commands out.
// ----------------------------------------------------------------------------
interface tvp_sample_if #(
  parameter int POSITION_BITS = 16
);
  logic                     valid;
  logic                     ready;
  logic [POSITION_BITS-1:0] position;

  modport source (output valid, output position, input ready);
  modport sink   (input valid, input position, output ready);
endinterface

interface tvp_command_if;
  logic       valid;
  logic       ready;
  logic [7:0] velocity;
  logic       position_fault;

  modport source (output valid, output velocity, output position_fault, input ready);
  modport sink   (input valid, input velocity, input position_fault, output ready);
endinterface

[rtl/tvp_sqrt_stage.sv]
// ----------------------------------------------------------------------------
// tvp_sqrt_stage
// A slice of the restoring floor square root: STEPS result bits per stage.
// ----------------------------------------------------------------------------
module tvp_sqrt_stage #(
  parameter int FIRST_STEP = 0,
  parameter int STEPS      = 4
) (
  input  tvp_pkg::tvp_sqrt_t din,
  output tvp_pkg::tvp_sqrt_t dout
);
  import tvp_pkg::*;

  always_comb begin
    logic [SQRT_IN_BITS-1:0] rem;
    logic [SQRT_IN_BITS-1:0] root;
    logic [SQRT_IN_BITS-1:0] bitv;
    logic [SQRT_IN_BITS:0]   trial;
    rem  = din.rem;
    root = din.root;
    for (int i = 0; i < STEPS; i++) begin
      bitv  = SQRT_IN_BITS'(1) << (SQRT_IN_BITS - 2 - 2 * (FIRST_STEP + i));
      trial = {1'b0, root} + {1'b0, bitv};
      if ({1'b0, rem} >= trial) begin
        rem  = rem - trial[SQRT_IN_BITS-1:0];
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
    end
    dout.rem  = rem;
    dout.root = root;
  end

endmodule

[rtl/trapezoidal_velocity_profile_unit.sv]
// ----------------------------------------------------------------------------
// trapezoidal_velocity_profile_unit
// Commanded velocity on a trapezoidal move profile, one per encoder sample.
//
// Usage:
//  - sample  : valid/ready channel of encoder positions (one transaction each).
//  - command : valid/ready channel of results, one transaction per sample:
//              velocity and position_fault (position outside start..end,
//              velocity then forced to 0).
//  - wr_en / wr_index / wr_data : register writes (move_start, move_end,
//              speed_limit, accel_limit), taken on any edge with wr_en high.
//              Write only while no sample is in flight.
//  - Pipeline: six register stages; the first loads at the accepting edge, and
//    command valid rises once the sample reaches the sixth (output) register.
//  - Throughput: one sample per cycle while command.ready is high; every stage
//    is a register with its own valid bit, so a new sample can enter each cycle.
//  - Stall: when command.ready is low the pipeline fills up behind the
//    output register; bubbles are squeezed out, and sample.ready drops only
//    once all six stages hold data. Nothing is dropped or repeated.
//  - Reset (rst, synchronous): clears all valid bits and loads the
//    registers with 0, 0, 0, 1.
// ----------------------------------------------------------------------------
module trapezoidal_velocity_profile_unit #(
  parameter int POSITION_BITS = tvp_pkg::POSITION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  tvp_sample_if.sink                          sample,
  tvp_command_if.source                       command,
  input  logic                                wr_en,
  input  logic [tvp_pkg::CFG_INDEX_BITS-1:0]  wr_index,
  input  logic [POSITION_BITS-1:0]            wr_data
);
  import tvp_pkg::*;

  // distance times 2*accel fits this width
  localparam int PROD_BITS = POSITION_BITS + ACCEL_BITS + 1;
  localparam int NSTAGE    = 6;

  // --------------------------------------------------------------------------
  // Configuration registers. speed_limit squared is kept alongside so the
  // braking comparisons need no multiplier in the item path.
  // --------------------------------------------------------------------------
  logic [POSITION_BITS-1:0]  move_start;
  logic [POSITION_BITS-1:0]  move_end;
  logic [SPEED_BITS-1:0]     speed_limit;
  logic [ACCEL_BITS-1:0]     accel_limit;
  logic [SQRT_IN_BITS-1:0]   speed_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      move_start  <= '0;
      move_end    <= '0;
      speed_limit <= '0;
      accel_limit <= ACCEL_BITS'(1);
      speed_sq    <= '0;
    end else if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_MOVE_START:  move_start <= wr_data;
        REG_MOVE_END:    move_end   <= wr_data;
        REG_SPEED_LIMIT: begin
          speed_limit <= wr_data[SPEED_BITS-1:0];
          speed_sq    <= SQRT_IN_BITS'(wr_data[SPEED_BITS-1:0]) *
                         SQRT_IN_BITS'(wr_data[SPEED_BITS-1:0]);
        end
        REG_ACCEL_LIMIT: accel_limit <= wr_data[ACCEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // 2*accel, with zero read as one
  logic [ACCEL_BITS:0] accel2;
  assign accel2 = (accel_limit == '0) ? (ACCEL_BITS+1)'(2) : {accel_limit, 1'b0};

  // --------------------------------------------------------------------------
  // Pipeline control: stage k advances when it is empty or stage k+1 moves.
  // --------------------------------------------------------------------------
  logic [NSTAGE:1] vld;
  logic [NSTAGE:1] adv;

  always_comb begin
    adv[NSTAGE] = !vld[NSTAGE] || command.ready;
    for (int k = NSTAGE - 1; k >= 1; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign sample.ready = adv[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) begin
        vld[1] <= sample.valid;
      end
      for (int k = 2; k <= NSTAGE; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: distances travelled / remaining, range check.
  // --------------------------------------------------------------------------
  logic [POSITION_BITS:0]   dist_done;
  logic [POSITION_BITS:0]   dist_left;
  logic [POSITION_BITS-1:0] done1;
  logic [POSITION_BITS-1:0] left1;
  logic                     fault1;

  assign dist_done = {1'b0, sample.position} - {1'b0, move_start};
  assign dist_left = {1'b0, move_end} - {1'b0, sample.position};

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      done1  <= dist_done[POSITION_BITS-1:0];
      left1  <= dist_left[POSITION_BITS-1:0];
      fault1 <= dist_done[POSITION_BITS] | dist_left[POSITION_BITS];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: scale both distances by 2*accel; remaining distance saturated
  // to the velocity range for the final clamp.
  // --------------------------------------------------------------------------
  logic [PROD_BITS-1:0]  prod_done2;
  logic [PROD_BITS-1:0]  prod_left2;
  logic [SPEED_BITS-1:0] left2;
  logic                  fault2;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      prod_done2 <= PROD_BITS'(done1) * PROD_BITS'(accel2);
      prod_left2 <= PROD_BITS'(left1) * PROD_BITS'(accel2);
      left2      <= (left1 > POSITION_BITS'({SPEED_BITS{1'b1}})) ? '1
                                                                 : left1[SPEED_BITS-1:0];
      fault2     <= fault1;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: phase select. With D = floor(v^2 / 2a):
  //   accelerate : done < D   <=>  2a*(done+1) <= v^2
  //   cruise     : D < left   <=>  v^2 < 2a*left
  // The root argument saturates at 16 bits: beyond that the root exceeds
  // any speed_limit and the clamp takes over.
  // --------------------------------------------------------------------------
  logic                 accel_ph;
  logic                 cruise_ph;
  logic [PROD_BITS-1:0] root_arg;
  tvp_sqrt_t            sq3;
  logic                 cruise3;
  logic [SPEED_BITS-1:0] left3;
  logic                 fault3;

  assign accel_ph  = (prod_done2 + PROD_BITS'(accel2)) <= PROD_BITS'(speed_sq);
  assign cruise_ph = PROD_BITS'(speed_sq) < prod_left2;
  assign root_arg  = accel_ph ? prod_done2 : prod_left2;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      sq3.rem  <= (root_arg[PROD_BITS-1:SQRT_IN_BITS] != '0) ? '1
                                                             : root_arg[SQRT_IN_BITS-1:0];
      sq3.root <= '0;
      cruise3  <= !accel_ph && cruise_ph;
      left3    <= left2;
      fault3   <= fault2;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 4 and 5: floor square root, four result bits per stage.
  // --------------------------------------------------------------------------
  tvp_sqrt_t             sq4_d;
  tvp_sqrt_t             sq4;
  logic                  cruise4;
  logic [SPEED_BITS-1:0] left4;
  logic                  fault4;

  tvp_sqrt_stage #(
    .FIRST_STEP (0),
    .STEPS      (SQRT_STEPS_PER_STAGE)
  ) u_sqrt_hi (
    .din  (sq3),
    .dout (sq4_d)
  );

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      sq4     <= sq4_d;
      cruise4 <= cruise3;
      left4   <= left3;
      fault4  <= fault3;
    end
  end

  tvp_sqrt_t             sq5_d;
  logic [SPEED_BITS-1:0] root5;
  logic                  cruise5;
  logic [SPEED_BITS-1:0] left5;
  logic                  fault5;

  tvp_sqrt_stage #(
    .FIRST_STEP (SQRT_STEPS_PER_STAGE),
    .STEPS      (SQRT_STEPS - SQRT_STEPS_PER_STAGE)
  ) u_sqrt_lo (
    .din  (sq4),
    .dout (sq5_d)
  );

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      root5   <= sq5_d.root[SPEED_BITS-1:0];
      cruise5 <= cruise4;
      left5   <= left4;
      fault5  <= fault4;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: clamp to speed_limit and remaining distance, zero on fault; output register.
  // --------------------------------------------------------------------------
  logic [SPEED_BITS-1:0] vel_pick;
  logic [SPEED_BITS-1:0] vel_next;

  always_comb begin
    vel_pick = cruise5 ? speed_limit : root5;
    if (vel_pick > speed_limit) begin
      vel_pick = speed_limit;
    end
    if (vel_pick > left5) begin
      vel_pick = left5;
    end
    vel_next = fault5 ? '0 : vel_pick;
  end

  logic [SPEED_BITS-1:0] velocity;
  logic                  position_fault;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      velocity       <= vel_next;
      position_fault <= fault5;
    end
  end

  assign command.valid          = vld[NSTAGE];
  assign command.velocity       = velocity;
  assign command.position_fault = position_fault;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    command.valid && command.position_fault |-> command.velocity == '0)
    else $error("fault result with nonzero velocity");

  a_speed_clamp: assert property (@(posedge clk) disable iff (rst)
    command.valid |-> command.velocity <= speed_limit)
    else $error("velocity above speed_limit");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready |=> vld[1])
    else $error("accepted sample missing from first stage");

  a_stall_keeps: assert property (@(posedge clk) disable iff (rst)
    vld[NSTAGE] && !command.ready |=> vld[NSTAGE] && $stable(velocity))
    else $error("output lost under stall");

endmodule
